/* hdl/pcc_pkg.sv */
// shared types and constants for the pearson correlation block
package pcc_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int SAMP_W    = 16;
  localparam int SUM_W     = SAMP_W + ADDR_W;
  localparam int DEV_W     = SAMP_W + 1;
  localparam int PRD_W     = 2 * DEV_W;
  localparam int ACC_W     = PRD_W + ADDR_W + 1;
  localparam int MAG_W     = ACC_W;
  localparam int VV_W      = 2 * ACC_W;
  localparam int Q_W       = 15;
  localparam int TT_W      = 2 * Q_W;
  localparam int PROD_W    = VV_W + TT_W;
  localparam int BIT_W     = $clog2(Q_W);
  localparam int PAIRS_W   = 11;
  localparam int CORR_W    = 16;

  typedef struct packed {
    logic [SAMP_W-1:0] x_sample;
    logic [SAMP_W-1:0] y_sample;
    logic              last;
  } in_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic                     defined;
    logic                     truncated;
    logic [PAIRS_W-1:0]       pairs_used;
  } out_t;

endpackage

/* hdl/pcc_store.sv */
// sample pair memory, one write port and one registered read port
module pcc_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [pcc_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [pcc_pkg::SAMP_W-1:0]    wr_x,
  input  logic [pcc_pkg::SAMP_W-1:0]    wr_y,
  input  logic                          rd_en,
  input  logic [pcc_pkg::ADDR_W-1:0]    rd_addr,
  output logic [pcc_pkg::SAMP_W-1:0]    rd_x,
  output logic [pcc_pkg::SAMP_W-1:0]    rd_y
);

  logic [pcc_pkg::SAMP_W-1:0] xmem [pcc_pkg::MAX_LEN];
  logic [pcc_pkg::SAMP_W-1:0] ymem [pcc_pkg::MAX_LEN];
  logic [pcc_pkg::SAMP_W-1:0] rd_x_r;
  logic [pcc_pkg::SAMP_W-1:0] rd_y_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      xmem[wr_addr] <= wr_x;
      ymem[wr_addr] <= wr_y;
    end
    if (rd_en) begin
      rd_x_r <= xmem[rd_addr];
      rd_y_r <= ymem[rd_addr];
    end
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule

/* hdl/pcc_div.sv */
// restoring divider, one quotient bit per cycle, for the means
module pcc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pcc_pkg::SUM_W-1:0]  dividend,
  input  logic [pcc_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [pcc_pkg::SAMP_W-1:0] quot
);

  localparam int STEP_W = $clog2(pcc_pkg::SUM_W + 1);

  logic                       busy_r;
  logic                       done_r;
  logic [STEP_W-1:0]          step_r;
  logic [pcc_pkg::CNT_W-1:0]  rem_r;
  logic [pcc_pkg::CNT_W-1:0]  dvs_r;
  logic [pcc_pkg::SUM_W-1:0]  dvd_r;
  logic [pcc_pkg::SUM_W-1:0]  quo_r;
  logic [pcc_pkg::CNT_W:0]    trial;
  logic                       fits;

  assign trial = {rem_r, dvd_r[pcc_pkg::SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(pcc_pkg::SUM_W);
        rem_r  <= '0;
        dvs_r  <= divisor;
        dvd_r  <= dividend;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? pcc_pkg::CNT_W'(trial - {1'b0, dvs_r})
                       : trial[pcc_pkg::CNT_W-1:0];
        quo_r  <= {quo_r[pcc_pkg::SUM_W-2:0], fits};
        dvd_r  <= dvd_r << 1;
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r[pcc_pkg::SAMP_W-1:0];

endmodule

/* hdl/pcc_mul.sv */
// shift-add multiplier, one multiplier bit per cycle
module pcc_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcc_pkg::VV_W-1:0]    a,
  input  logic [pcc_pkg::MAG_W-1:0]   b,
  output logic                        busy,
  output logic                        done,
  output logic [pcc_pkg::PROD_W-1:0]  p
);

  localparam int STEP_W = $clog2(pcc_pkg::MAG_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           step_r;
  logic [pcc_pkg::PROD_W-1:0]  ash_r;
  logic [pcc_pkg::MAG_W-1:0]   b_r;
  logic [pcc_pkg::PROD_W-1:0]  p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(pcc_pkg::MAG_W);
        ash_r  <= {{(pcc_pkg::PROD_W - pcc_pkg::VV_W){1'b0}}, a};
        b_r    <= b;
        p_r    <= '0;
      end else if (busy_r) begin
        if (b_r[0]) begin
          p_r <= p_r + ash_r;
        end
        ash_r  <= ash_r << 1;
        b_r    <= b_r >> 1;
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = p_r;

endmodule

/* hdl/pearson_correlation.sv */
// top level of the pearson correlation block
// usage:
//   in_data carries one (x, y) sample pair per transfer, last marks the final pair
//   of a data set; pairs beyond the store depth are dropped and reported
//   through the truncated flag of the result
//   out_data carries one result per data set, after the pair flagged last
// sequence:
//   pairs are taken only in the load state; after the last pair the block runs
//   two serial dividers for the means, a pass over the stored pairs at one
//   pair per cycle, then a bit-by-bit root search built on one shift-add
//   multiplier: two products and then 15 trial products, one per result bit
// reset: rst_n is synchronous, active low; it empties the data set, the
//   memory contents are left as they are and are never read before written
// stall: a finished result sits in the output register; new pairs are
//   taken while it waits, and the next result waits until it is taken
module pearson_correlation (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pcc_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pcc_pkg::out_t   out_data
);

  typedef enum logic [3:0] {
    S_LOAD, S_DIVST, S_DIV, S_PASS, S_CHK, S_MAG, S_VVST, S_VV, S_TT, S_CMP, S_FIN
  } state_t;

  state_t state_r;

  // data set state
  logic [pcc_pkg::CNT_W-1:0]          cnt_r;
  logic [pcc_pkg::SUM_W-1:0]          sumx_r;
  logic [pcc_pkg::SUM_W-1:0]          sumy_r;
  logic                               ovf_r;
  logic signed [pcc_pkg::ACC_W-1:0]   cross_r;
  logic [pcc_pkg::ACC_W-1:0]          vx_r;
  logic [pcc_pkg::ACC_W-1:0]          vy_r;

  // second pass pipeline
  logic [pcc_pkg::CNT_W-1:0]          rd_addr_r;
  logic                               v1_r;
  logic                               v2_r;
  logic signed [pcc_pkg::PRD_W-1:0]   pxy_r;
  logic [pcc_pkg::PRD_W-1:0]          pxx_r;
  logic [pcc_pkg::PRD_W-1:0]          pyy_r;

  // root search
  logic [pcc_pkg::PROD_W-1:0]         rhs_r;
  logic [pcc_pkg::VV_W-1:0]           vv_r;
  logic [pcc_pkg::Q_W-1:0]            q_r;
  logic [pcc_pkg::BIT_W-1:0]          bit_r;
  logic signed [pcc_pkg::CORR_W-1:0]  corr_r;
  logic                               def_r;

  pcc_pkg::out_t                      out_r;
  logic                               out_valid_r;

  logic                               accept;
  logic                               room;
  logic                               rd_en;
  logic [pcc_pkg::SAMP_W-1:0]         rd_x;
  logic [pcc_pkg::SAMP_W-1:0]         rd_y;
  logic                               div_start;
  logic                               divx_done;
  logic                               divy_done;
  logic [pcc_pkg::SAMP_W-1:0]         mean_x;
  logic [pcc_pkg::SAMP_W-1:0]         mean_y;
  logic signed [pcc_pkg::DEV_W-1:0]   dx;
  logic signed [pcc_pkg::DEV_W-1:0]   dy;
  logic                               neg;
  logic [pcc_pkg::MAG_W-1:0]          mag;
  logic                               var_ok;
  logic [pcc_pkg::Q_W-1:0]            t;
  logic [pcc_pkg::TT_W-1:0]           tt;
  logic                               mul_start;
  logic                               mul_busy;
  logic                               mul_done;
  logic [pcc_pkg::VV_W-1:0]           mul_a;
  logic [pcc_pkg::MAG_W-1:0]          mul_b;
  logic [pcc_pkg::PROD_W-1:0]         mul_p;
  logic                               out_free;

  assign in_ready = (state_r == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign room     = cnt_r < pcc_pkg::CNT_W'(pcc_pkg::MAX_LEN);
  assign rd_en    = (state_r == S_PASS) && (rd_addr_r < cnt_r);
  assign div_start = (state_r == S_DIVST);

  pcc_store u_store (
    .clk     (clk),
    .wr_en   (accept && room),
    .wr_addr (cnt_r[pcc_pkg::ADDR_W-1:0]),
    .wr_x    (in_data.x_sample),
    .wr_y    (in_data.y_sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r[pcc_pkg::ADDR_W-1:0]),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  pcc_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sumx_r),
    .divisor  (cnt_r),
    .done     (divx_done),
    .quot     (mean_x)
  );

  pcc_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sumy_r),
    .divisor  (cnt_r),
    .done     (divy_done),
    .quot     (mean_y)
  );

  // deviations from the means, one stored pair per cycle
  assign dx = $signed({1'b0, rd_x}) - $signed({1'b0, mean_x});
  assign dy = $signed({1'b0, rd_y}) - $signed({1'b0, mean_y});

  assign neg    = cross_r[pcc_pkg::ACC_W-1];
  assign mag    = neg ? pcc_pkg::MAG_W'(-cross_r) : pcc_pkg::MAG_W'(cross_r);
  assign var_ok = (vx_r != '0) && (vy_r != '0);

  // trial root bit: accept t when vx*vy*t*t <= cross^2 * 2^30
  assign t  = q_r | (pcc_pkg::Q_W'(1) << bit_r);
  assign tt = pcc_pkg::TT_W'(t) * pcc_pkg::TT_W'(t);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = vv_r;
    mul_b     = pcc_pkg::MAG_W'(tt);
    case (state_r)
      S_CHK: begin
        mul_start = var_ok;
        mul_a     = pcc_pkg::VV_W'(mag);
        mul_b     = mag;
      end
      S_VVST: begin
        mul_start = 1'b1;
        mul_a     = pcc_pkg::VV_W'(vx_r);
        mul_b     = vy_r;
      end
      S_TT: begin
        mul_start = 1'b1;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  pcc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      sumx_r      <= '0;
      sumy_r      <= '0;
      ovf_r       <= 1'b0;
      cross_r     <= '0;
      vx_r        <= '0;
      vy_r        <= '0;
      rd_addr_r   <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // pass pipeline: read, deviation products, accumulate
      v1_r <= rd_en;
      v2_r <= v1_r;
      if (rd_en) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (v1_r) begin
        pxy_r <= dx * dy;
        pxx_r <= $unsigned(pcc_pkg::PRD_W'(dx) * pcc_pkg::PRD_W'(dx));
        pyy_r <= $unsigned(pcc_pkg::PRD_W'(dy) * pcc_pkg::PRD_W'(dy));
      end
      if (v2_r) begin
        cross_r <= cross_r + pcc_pkg::ACC_W'(pxy_r);
        vx_r    <= vx_r + pcc_pkg::ACC_W'(pxx_r);
        vy_r    <= vy_r + pcc_pkg::ACC_W'(pyy_r);
      end

      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              cnt_r  <= cnt_r + 1'b1;
              sumx_r <= sumx_r + pcc_pkg::SUM_W'(in_data.x_sample);
              sumy_r <= sumy_r + pcc_pkg::SUM_W'(in_data.y_sample);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_data.last) begin
              state_r <= S_DIVST;
            end
          end
        end
        S_DIVST: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (divx_done && divy_done) begin
            rd_addr_r <= '0;
            state_r   <= S_PASS;
          end
        end
        S_PASS: begin
          if (!rd_en && !v1_r && !v2_r) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          corr_r <= '0;
          def_r  <= var_ok;
          state_r <= var_ok ? S_MAG : S_FIN;
        end
        S_MAG: begin
          if (mul_done) begin
            rhs_r   <= mul_p << pcc_pkg::TT_W;
            state_r <= S_VVST;
          end
        end
        S_VVST: begin
          state_r <= S_VV;
        end
        S_VV: begin
          if (mul_done) begin
            vv_r    <= mul_p[pcc_pkg::VV_W-1:0];
            q_r     <= '0;
            bit_r   <= pcc_pkg::BIT_W'(pcc_pkg::Q_W - 1);
            state_r <= S_TT;
          end
        end
        S_TT: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (mul_done) begin
            if (mul_p <= rhs_r) begin
              q_r <= t;
            end
            if (bit_r == '0) begin
              state_r <= S_FIN;
              if (mul_p <= rhs_r) begin
                corr_r <= neg ? -$signed({1'b0, t}) : $signed({1'b0, t});
              end else begin
                corr_r <= neg ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
              end
            end else begin
              bit_r   <= bit_r - 1'b1;
              state_r <= S_TT;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_r.correlation <= corr_r;
            out_r.defined     <= def_r;
            out_r.truncated   <= ovf_r;
            out_r.pairs_used  <= pcc_pkg::PAIRS_W'(cnt_r);
            out_valid_r       <= 1'b1;
            cnt_r   <= '0;
            sumx_r  <= '0;
            sumy_r  <= '0;
            ovf_r   <= 1'b0;
            cross_r <= '0;
            vx_r    <= '0;
            vy_r    <= '0;
            state_r <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pair count never passes the store depth
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pcc_pkg::CNT_W'(pcc_pkg::MAX_LEN))
    else $error("pair count beyond store depth");

  // the pass only reads entries written in this data set
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_addr_r < cnt_r))
    else $error("read of unwritten entry");

  // an undefined result carries zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.defined) |-> (out_data.correlation == '0))
    else $error("undefined result not zero");

  // the multiplier is never restarted mid product
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");

endmodule
